/* hw/rtl/drpi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drpi_pkg
// Shared widths, constants, command word and arithmetic helpers for the
// dead reckoning pose integrator.
// ----------------------------------------------------------------------------
package drpi_pkg;

   // field widths
   localparam int VEL_W          = 16;
   localparam int RATE_W         = 8;
   localparam int POS_W          = 32;
   localparam int OUT_W          = 32;
   localparam int TRIG_FRAC_BITS = 15;
   localparam int SIN_W          = TRIG_FRAC_BITS + 2;

   // divider lanes
   localparam int NUM_LANES = 4;
   localparam int LANE_X    = 0;
   localparam int LANE_Y    = 1;
   localparam int LANE_Z    = 2;
   localparam int LANE_YAW  = 3;

   // step counts (two bits retired per cycle in divider and modulo unit)
   localparam int DIV_STEPS = VEL_W / 2;
   localparam int MOD_STEPS = (POS_W + 1) / 2;
   localparam int MOD_BITS  = 2 * MOD_STEPS;
   localparam int MUL_STEPS = 5;
   localparam int CNT_MAX   = (DIV_STEPS > MOD_STEPS) ?
                              ((DIV_STEPS > MUL_STEPS) ? DIV_STEPS : MUL_STEPS) :
                              ((MOD_STEPS > MUL_STEPS) ? MOD_STEPS : MUL_STEPS);
   localparam int CNT_W     = $clog2(CNT_MAX);
   localparam int MUL_IDX_W = $clog2(MUL_STEPS);

   // multiply / accumulate order of the rotation
   localparam logic [MUL_IDX_W-1:0] MUL_CX  = MUL_IDX_W'(0);  // cos * sx
   localparam logic [MUL_IDX_W-1:0] MUL_SY  = MUL_IDX_W'(1);  // sin * sy
   localparam logic [MUL_IDX_W-1:0] MUL_SX  = MUL_IDX_W'(2);  // sin * sx
   localparam logic [MUL_IDX_W-1:0] MUL_CY  = MUL_IDX_W'(3);  // cos * sy
   localparam logic [MUL_IDX_W-1:0] MUL_END = MUL_IDX_W'(4);  // drain last product

   localparam int PROD_W = SIN_W + VEL_W;
   localparam int ACC_W  = PROD_W + 1;
   localparam int STEP_W = ACC_W - TRIG_FRAC_BITS;
   localparam int SUM_W  = ((POS_W > STEP_W) ? POS_W : STEP_W) + 2;

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [POS_W-1:0]        POS_BIAS = {1'b1, {(POS_W-1){1'b0}}};

   // angles in whole degrees
   localparam int ANG_W   = 9;
   localparam int QUARTER = 90;
   localparam int QIDX_W  = $clog2(QUARTER + 1);
   localparam logic [ANG_W-1:0] DEG_90  = ANG_W'(90);
   localparam logic [ANG_W-1:0] DEG_180 = ANG_W'(180);
   localparam logic [ANG_W-1:0] DEG_270 = ANG_W'(270);
   localparam logic [ANG_W-1:0] DEG_360 = ANG_W'(360);
   // 2^(POS_W-1) mod 360: removes the bias added before the serial modulo
   localparam int unsigned      BIAS_MOD = int'((64'd1 << (POS_W - 1)) % 64'd360);
   localparam logic [ANG_W-1:0] BIAS_DEG = ANG_W'(BIAS_MOD);
   localparam logic [ANG_W-1:0] BIAS_CMP = ANG_W'(360 - BIAS_MOD);

   // configuration
   localparam int                CSR_ADDR_W = 3;
   localparam int                CSR_DATA_W = 32;
   localparam int                CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_DIVISOR = CSR_IDX_W'(0);
   localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(10);

   // controller to datapath command word
   typedef struct packed {
      logic                 load;
      logic                 div_step;
      logic                 head_upd;
      logic                 mod_step;
      logic                 trig;
      logic                 mul_step;
      logic [MUL_IDX_W-1:0] mul_idx;
      logic                 pos_upd;
      logic                 out_load;
   } drpi_cmd_type;

   // quarter-wave sine table, Q(TRIG_FRAC_BITS), 0..90 degrees
   typedef logic [TRIG_FRAC_BITS:0] sin_mag_type;
   typedef sin_mag_type sin_tab_type [0:QUARTER];

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

   // Taylor series in Q30, evaluated at elaboration only
   function automatic sin_tab_type build_sin_tab();
      sin_tab_type       tab;
      logic [63:0]       x;
      logic [63:0]       x2;
      logic [63:0]       term;
      logic signed [63:0] sum;
      logic [63:0]       rnd;
      for (int k = 0; k <= QUARTER; k++) begin
         x    = (64'(k) * PI_Q30) / 64'd180;
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > $signed(ONE_Q30)) begin
            sum = $signed(ONE_Q30);
         end
         rnd    = ($unsigned(sum) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
         tab[k] = rnd[TRIG_FRAC_BITS:0];
      end
      return tab;
   endfunction

   localparam sin_tab_type SIN_TAB = build_sin_tab();

   // sine of a whole angle 0..359 by quadrant symmetry
   function automatic logic signed [SIN_W-1:0] sin_deg(input logic [ANG_W-1:0] ang);
      logic [ANG_W-1:0]  idx;
      logic              neg;
      logic [SIN_W-1:0]  mag;
      if (ang < DEG_90) begin
         idx = ang;
         neg = 1'b0;
      end else if (ang < DEG_180) begin
         idx = DEG_180 - ang;
         neg = 1'b0;
      end else if (ang < DEG_270) begin
         idx = ang - DEG_180;
         neg = 1'b1;
      end else begin
         idx = DEG_360 - ang;
         neg = 1'b1;
      end
      mag = SIN_W'(SIN_TAB[idx[QIDX_W-1:0]]);
      return neg ? $signed(-mag) : $signed(mag);
   endfunction

   // clamp a widened sum to the signed accumulator range
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic ovf;
      ovf = (v[SUM_W-1:POS_W-1] != {(SUM_W-POS_W+1){v[SUM_W-1]}});
      if (ovf) begin
         return v[SUM_W-1] ? POS_MIN : POS_MAX;
      end
      return v[POS_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/drpi_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drpi_req_if / drpi_rsp_if
// Valid/ready channels carrying velocity words in and pose words out.
// ----------------------------------------------------------------------------
interface drpi_req_if;
   import drpi_pkg::*;

   logic              valid;
   logic              ready;
   logic signed [VEL_W-1:0] vel_x;
   logic signed [VEL_W-1:0] vel_y;
   logic signed [VEL_W-1:0] vel_z;
   logic signed [VEL_W-1:0] yaw_rate;

   modport source (output valid, output vel_x, output vel_y, output vel_z,
                   output yaw_rate, input ready);
   modport sink   (input valid, input vel_x, input vel_y, input vel_z,
                   input yaw_rate, output ready);
endinterface

interface drpi_rsp_if;
   import drpi_pkg::*;

   logic              valid;
   logic              ready;
   logic signed [OUT_W-1:0] pos_x;
   logic signed [OUT_W-1:0] pos_y;
   logic signed [OUT_W-1:0] pos_z;
   logic signed [OUT_W-1:0] heading;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output heading, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input heading, output ready);
endinterface
`default_nettype wire

/* hw/rtl/drpi_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drpi_ctrl
// Sequencer: steps one word through divide, heading, modulo, table,
// multiply and position phases, then hands it to the output register.
// ----------------------------------------------------------------------------
module drpi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output drpi_pkg::drpi_cmd_type cmd
);
   import drpi_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_DIV  = 8'b0000_0010,
      ST_HEAD = 8'b0000_0100,
      ST_MOD  = 8'b0000_1000,
      ST_TRIG = 8'b0001_0000,
      ST_MUL  = 8'b0010_0000,
      ST_POS  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } drpi_state_type;

   drpi_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_idx = cnt_ff[MUL_IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            cmd.head_upd = 1'b1;
            cnt_in       = '0;
            state_in     = ST_MOD;
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MOD_STEPS - 1)) begin
               state_in = ST_TRIG;
            end
         end
         ST_TRIG: begin
            cmd.trig = 1'b1;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            cmd.pos_upd = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/drpi_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drpi_datapath
// Four radix-4 dividers, saturating accumulators, serial mod-360 unit,
// sine table, one shared multiplier and the output register.
// ----------------------------------------------------------------------------
module drpi_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  drpi_pkg::drpi_cmd_type              cmd,
   input  logic signed [drpi_pkg::VEL_W-1:0]   vel_x,
   input  logic signed [drpi_pkg::VEL_W-1:0]   vel_y,
   input  logic signed [drpi_pkg::VEL_W-1:0]   vel_z,
   input  logic signed [drpi_pkg::VEL_W-1:0]   yaw_rate,
   input  logic        [drpi_pkg::RATE_W-1:0]  rate_divisor,
   output logic signed [drpi_pkg::OUT_W-1:0]   pos_x,
   output logic signed [drpi_pkg::OUT_W-1:0]   pos_y,
   output logic signed [drpi_pkg::OUT_W-1:0]   pos_z,
   output logic signed [drpi_pkg::OUT_W-1:0]   heading
);
   import drpi_pkg::*;

   // divider lanes
   logic [RATE_W-1:0]        div_ff, div_in;
   logic [VEL_W-1:0]         mag_ff [NUM_LANES];
   logic [VEL_W-1:0]         mag_in [NUM_LANES];
   logic [RATE_W-1:0]        rem_ff [NUM_LANES];
   logic [RATE_W-1:0]        rem_in [NUM_LANES];
   logic                     neg_ff [NUM_LANES];
   logic                     neg_in [NUM_LANES];
   logic signed [VEL_W-1:0]  vel_arr [NUM_LANES];
   logic signed [VEL_W-1:0]  quo [NUM_LANES];

   // accumulators
   logic signed [POS_W-1:0]  xp_ff, xp_in, yp_ff, yp_in;
   logic signed [POS_W-1:0]  alt_ff, alt_in, hd_ff, hd_in;
   logic signed [POS_W-1:0]  hd_sum;

   // modulo 360
   logic [MOD_BITS-1:0]      modsh_ff, modsh_in;
   logic [ANG_W-1:0]         modr_ff, modr_in;
   logic [ANG_W:0]           m1, m2;
   logic [ANG_W-1:0]         ang, ang_cos;

   // trig and rotation
   logic signed [SIN_W-1:0]  sin_ff, sin_in, cos_ff, cos_in;
   logic signed [SIN_W-1:0]  op_a;
   logic signed [VEL_W-1:0]  op_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  rx_ff, rx_in, ry_ff, ry_in;

   // position update
   logic signed [ACC_W-1:0]  flx, fly;
   logic                     fracx, fracy;
   logic signed [SUM_W-1:0]  basex, basey;

   // output word
   logic signed [OUT_W-1:0]  px_ff, py_ff, pz_ff, ph_ff;

   assign vel_arr[LANE_X]   = vel_x;
   assign vel_arr[LANE_Y]   = vel_y;
   assign vel_arr[LANE_Z]   = vel_z;
   assign vel_arr[LANE_YAW] = yaw_rate;

   // ---- dividers: magnitude restoring division, two quotient bits a cycle
   always_comb begin
      logic [RATE_W:0] r1;
      logic [RATE_W:0] r2;
      logic            q1;
      logic            q2;
      div_in = div_ff;
      for (int i = 0; i < NUM_LANES; i++) begin
         mag_in[i] = mag_ff[i];
         rem_in[i] = rem_ff[i];
         neg_in[i] = neg_ff[i];
         quo[i]    = neg_ff[i] ? $signed(-mag_ff[i]) : $signed(mag_ff[i]);
         r1 = {rem_ff[i], mag_ff[i][VEL_W-1]};
         q1 = (r1 >= {1'b0, div_ff});
         if (q1) begin
            r1 = r1 - {1'b0, div_ff};
         end
         r2 = {r1[RATE_W-1:0], mag_ff[i][VEL_W-2]};
         q2 = (r2 >= {1'b0, div_ff});
         if (q2) begin
            r2 = r2 - {1'b0, div_ff};
         end
         if (cmd.load) begin
            mag_in[i] = vel_arr[i][VEL_W-1] ? -vel_arr[i] : vel_arr[i];
            rem_in[i] = '0;
            neg_in[i] = vel_arr[i][VEL_W-1];
         end else if (cmd.div_step) begin
            mag_in[i] = {mag_ff[i][VEL_W-3:0], q1, q2};
            rem_in[i] = r2[RATE_W-1:0];
         end
      end
      if (cmd.load) begin
         // a divisor of zero passes the velocities through
         div_in = (rate_divisor == '0) ? RATE_W'(1) : rate_divisor;
      end
   end

   // ---- altitude / heading, then mod 360 of the biased heading
   assign hd_sum = sat_pos(SUM_W'(hd_ff) + SUM_W'(quo[LANE_YAW]));

   always_comb begin
      alt_in   = alt_ff;
      hd_in    = hd_ff;
      modsh_in = modsh_ff;
      modr_in  = modr_ff;
      m1 = {modr_ff, modsh_ff[MOD_BITS-1]};
      if (m1 >= {1'b0, DEG_360}) begin
         m1 = m1 - {1'b0, DEG_360};
      end
      m2 = {m1[ANG_W-1:0], modsh_ff[MOD_BITS-2]};
      if (m2 >= {1'b0, DEG_360}) begin
         m2 = m2 - {1'b0, DEG_360};
      end
      if (cmd.head_upd) begin
         alt_in   = sat_pos(SUM_W'(alt_ff) + SUM_W'(quo[LANE_Z]));
         hd_in    = hd_sum;
         modsh_in = MOD_BITS'($unsigned(hd_sum) ^ POS_BIAS);
         modr_in  = '0;
      end else if (cmd.mod_step) begin
         modsh_in = modsh_ff << 2;
         modr_in  = m2[ANG_W-1:0];
      end
   end

   // ---- remove bias, table lookup
   always_comb begin
      ang     = (modr_ff >= BIAS_DEG) ? (modr_ff - BIAS_DEG) : (modr_ff + BIAS_CMP);
      ang_cos = (ang >= DEG_270) ? (ang - DEG_270) : (ang + DEG_90);
      sin_in  = cmd.trig ? sin_deg(ang) : sin_ff;
      cos_in  = cmd.trig ? sin_deg(ang_cos) : cos_ff;
   end

   // ---- rotation: one product a cycle, accumulated in the next cycle
   always_comb begin
      op_a = ((cmd.mul_idx == MUL_CX) || (cmd.mul_idx == MUL_CY)) ? cos_ff : sin_ff;
      op_b = ((cmd.mul_idx == MUL_CX) || (cmd.mul_idx == MUL_SX)) ?
             quo[LANE_X] : quo[LANE_Y];
      prod_in = cmd.mul_step ? (PROD_W'(op_a) * PROD_W'(op_b)) : prod_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      if (cmd.mul_step) begin
         case (cmd.mul_idx)
            MUL_SY:  rx_in = ACC_W'(prod_ff);
            MUL_SX:  rx_in = rx_ff - ACC_W'(prod_ff);
            MUL_CY:  ry_in = ACC_W'(prod_ff);
            MUL_END: ry_in = ry_ff + ACC_W'(prod_ff);
            default: ;
         endcase
      end
   end

   // ---- position: truncate pos + r / 2^F toward zero, then clamp
   always_comb begin
      flx   = rx_ff >>> TRIG_FRAC_BITS;
      fly   = ry_ff >>> TRIG_FRAC_BITS;
      fracx = |rx_ff[TRIG_FRAC_BITS-1:0];
      fracy = |ry_ff[TRIG_FRAC_BITS-1:0];
      basex = SUM_W'(xp_ff) + SUM_W'(flx);
      basey = SUM_W'(yp_ff) + SUM_W'(fly);
      if (fracx && basex[SUM_W-1]) begin
         basex = basex + SUM_W'(1);
      end
      if (fracy && basey[SUM_W-1]) begin
         basey = basey + SUM_W'(1);
      end
      xp_in = cmd.pos_upd ? sat_pos(basex) : xp_ff;
      yp_in = cmd.pos_upd ? sat_pos(basey) : yp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xp_ff  <= '0;
         yp_ff  <= '0;
         alt_ff <= '0;
         hd_ff  <= '0;
      end else begin
         xp_ff  <= xp_in;
         yp_ff  <= yp_in;
         alt_ff <= alt_in;
         hd_ff  <= hd_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff   <= div_in;
      mag_ff   <= mag_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      modsh_ff <= modsh_in;
      modr_ff  <= modr_in;
      sin_ff   <= sin_in;
      cos_ff   <= cos_in;
      prod_ff  <= prod_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      if (cmd.out_load) begin
         px_ff <= OUT_W'(xp_ff);
         py_ff <= OUT_W'(yp_ff);
         pz_ff <= OUT_W'(alt_ff);
         ph_ff <= OUT_W'(hd_ff);
      end
   end

   assign pos_x   = px_ff;
   assign pos_y   = py_ff;
   assign pos_z   = pz_ff;
   assign heading = ph_ff;

endmodule
`default_nettype wire

/* hw/rtl/dead_reckoning_pose_integrator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dead_reckoning_pose_integrator
// Integrates x/y position, altitude and heading from velocity words.
// ----------------------------------------------------------------------------
// Each velocity word (vel_x, vel_y, vel_z, yaw_rate) is divided by
// rate_divisor, truncating toward zero (zero acts as one); the z and yaw
// steps add to altitude and heading, the x/y step is rotated by the new
// heading (Q1.15 sine/cosine from a quarter-wave table at heading mod 360)
// and added to the x/y position, truncated toward zero. All four
// accumulators saturate at 32 bits and are returned as one pose word per
// velocity word. One word at a time is in flight: a word passes from
// acceptance to the output register through the radix-4 dividers, the
// two-bit-a-cycle mod-360 unit and the shared 17x16 multiplier. The next
// word is taken while the previous pose still waits in the output
// register. rate_divisor sits at byte address 0 of the CSR port, resets
// to 10 and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module dead_reckoning_pose_integrator (
   input  logic                               clock,
   input  logic                               reset,
   drpi_req_if.sink                           req_ch,
   drpi_rsp_if.source                         rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [drpi_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [drpi_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [drpi_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import drpi_pkg::*;

   drpi_cmd_type        cmd;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic                csr_wr;
   logic [CSR_IDX_W-1:0] csr_idx;

   // ---- CSR: single register, pready held high
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign rate_in    = (csr_wr && (csr_idx == REG_RATE_DIVISOR)) ?
                       csr_pwdata[RATE_W-1:0] : rate_ff;
   assign csr_prdata = (csr_idx == REG_RATE_DIVISOR) ?
                       CSR_DATA_W'(rate_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else begin
         rate_ff <= rate_in;
      end
   end

   // ---- sequencer
   drpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // ---- arithmetic and state
   drpi_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .vel_x        (req_ch.vel_x),
      .vel_y        (req_ch.vel_y),
      .vel_z        (req_ch.vel_z),
      .yaw_rate     (req_ch.yaw_rate),
      .rate_divisor (rate_ff),
      .pos_x        (rsp_ch.pos_x),
      .pos_y        (rsp_ch.pos_y),
      .pos_z        (rsp_ch.pos_z),
      .heading      (rsp_ch.heading)
   );

endmodule
`default_nettype wire

/* hw/rtl/drpi_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drpi_checker
// Port-level checks on the pose integrator, bound to the top level.
// ----------------------------------------------------------------------------
module drpi_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [drpi_pkg::OUT_W-1:0]  rsp_pos_x,
   input logic signed [drpi_pkg::OUT_W-1:0]  rsp_pos_y,
   input logic signed [drpi_pkg::OUT_W-1:0]  rsp_pos_z,
   input logic signed [drpi_pkg::OUT_W-1:0]  rsp_heading
);
   import drpi_pkg::*;

   // out of reset: idle, nothing to deliver
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("not idle after reset");

   // one word in flight: busy right after taking a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready again straight after accept");

   // a new pose only appears once a word has been worked on
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("pose appeared while idle");

   // stalled pose word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable({rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_heading})))
      else $error("stalled pose word changed");

endmodule

bind dead_reckoning_pose_integrator drpi_checker u_drpi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_pos_x   (rsp_ch.pos_x),
   .rsp_pos_y   (rsp_ch.pos_y),
   .rsp_pos_z   (rsp_ch.pos_z),
   .rsp_heading (rsp_ch.heading)
);
`default_nettype wire
